// File: design/cps_pkg.sv
// Shared constants, types and tables for the cart-pole physics step block.
`default_nettype none
package cps_pkg;

   localparam int FRAC_BITS     = 16;
   localparam bit SEMI_IMPLICIT = 1'b0;
   localparam int VAL_W         = 32;
   localparam int CFG_W         = 31;
   localparam int ANG_LIM_W     = 18;

   // Divider: dividend is |a| shifted up by FRAC_BITS.
   localparam int DIV_BITS      = VAL_W + FRAC_BITS;

   // Angle reduction: theta in Q30 and its remainder by two pi.
   localparam int ANG_SHIFT     = 30 - FRAC_BITS;
   localparam int Z_W           = VAL_W + ANG_SHIFT;
   localparam int RED_TOP       = 29 - FRAC_BITS;

   // CORDIC datapath.
   localparam int CORDIC_STEPS  = 30;
   localparam int CZ_W          = 34;
   localparam int FOLD_W        = 36;

   localparam longint Q30_TWO_PI  = 64'sd6746518852;
   localparam longint Q30_PI      = 64'sd3373259426;
   localparam longint Q30_HALF_PI = 64'sd1686629713;
   localparam longint CORDIC_GAIN = 64'sd652032874;

   localparam longint FOUR_THIRDS = (64'sd4 <<< FRAC_BITS) / 3;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [2:0] {
      REG_GRAVITY     = 3'd0,
      REG_PUSH_FORCE  = 3'd1,
      REG_TIME_STEP   = 3'd2,
      REG_POLE_MASS   = 3'd3,
      REG_TOTAL_MASS  = 3'd4,
      REG_HALF_LENGTH = 3'd5,
      REG_X_LIMIT     = 3'd6,
      REG_ANGLE_LIMIT = 3'd7
   } reg_index_type;

   localparam logic CMD_STEP = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Elementary angles atan(2^-i) in Q30.
   function automatic logic signed [CZ_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CZ_W-1:0] r;
      case (idx)
         5'd0:  r = 34'sd843314857;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043837;
         5'd3:  r = 34'sd133525159;
         5'd4:  r = 34'sd67021687;
         5'd5:  r = 34'sd33543516;
         5'd6:  r = 34'sd16775851;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194283;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048576;
         5'd11: r = 34'sd524288;
         5'd12: r = 34'sd262144;
         5'd13: r = 34'sd131072;
         5'd14: r = 34'sd65536;
         5'd15: r = 34'sd32768;
         5'd16: r = 34'sd16384;
         5'd17: r = 34'sd8192;
         5'd18: r = 34'sd4096;
         5'd19: r = 34'sd2048;
         5'd20: r = 34'sd1024;
         5'd21: r = 34'sd512;
         5'd22: r = 34'sd256;
         5'd23: r = 34'sd128;
         5'd24: r = 34'sd64;
         5'd25: r = 34'sd32;
         5'd26: r = 34'sd16;
         5'd27: r = 34'sd8;
         5'd28: r = 34'sd4;
         5'd29: r = 34'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/cps_req_if.sv
// Request channel of the cart-pole step block: step or load beats.
`default_nettype none
interface cps_req_if import cps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic                    push_right;
   logic signed [VAL_W-1:0] load_pos;
   logic signed [VAL_W-1:0] load_vel;
   logic signed [VAL_W-1:0] load_angle;
   logic signed [VAL_W-1:0] load_ang_vel;

   modport source(output valid, cmd, push_right, load_pos, load_vel, load_angle,
                  load_ang_vel, input ready);
   modport sink(input valid, cmd, push_right, load_pos, load_vel, load_angle,
                load_ang_vel, output ready);
endinterface
`default_nettype wire

// File: design/cps_rsp_if.sv
// Response channel of the cart-pole step block: new state and reward beats.
`default_nettype none
interface cps_rsp_if import cps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] cart_position;
   logic signed [VAL_W-1:0] cart_velocity;
   logic signed [VAL_W-1:0] pole_angle;
   logic signed [VAL_W-1:0] pole_rate;
   logic                    terminated;
   logic                    reward;
   logic [VAL_W-1:0]        reward_total;

   modport source(output valid, cart_position, cart_velocity, pole_angle, pole_rate,
                  terminated, reward, reward_total, input ready);
   modport sink(input valid, cart_position, cart_velocity, pole_angle, pole_rate,
                terminated, reward, reward_total, output ready);
endinterface
`default_nettype wire

// File: design/cart_pole_physics_step.sv
// Cart-pole physics step: fixed-point dynamics with a shared multiply/divide datapath.
//
// A load beat sets the state and answers through ST_DONE once the output
// register is free. A step beat runs a small sequencer: angle reduction
// modulo two pi, a fold, 30 CORDIC rotations and a scaling of sine and
// cosine, then a 27-operation program over one shared 32x32 multiplier
// (15 products), one shared restoring divider (four quotients) and a
// saturating adder (8 sums), then scoring and the write into the output
// register. The divider dominates the step time. The request side is ready
// only while no item is in work; a finished response waits in the output
// register and does not block the next request.
`default_nettype none
module cart_pole_physics_step import cps_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   cps_req_if.sink          req_bus,
   cps_rsp_if.source        rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_REDUCE, ST_FOLD, ST_CORDIC, ST_TRIG, ST_ISSUE, ST_MUL,
      ST_DIV_INIT, ST_DIV_RUN, ST_WB, ST_SCORE, ST_DONE
   } state_type;

   typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_ADD, OP_SUB} op_type;

   localparam logic [4:0] PC_LAST = 5'd26;

   typedef logic signed [VAL_W-1:0] val_type;

   function automatic val_type sat_64(input logic signed [63:0] v);
      val_type r;
      if (v > 64'sd2147483647)       r = VAL_MAX;
      else if (v < -64'sd2147483648) r = VAL_MIN;
      else                           r = v[VAL_W-1:0];
      return r;
   endfunction

   state_type state_ff;
   logic [5:0] cnt_ff;
   logic [4:0] pc_ff;
   op_type     op_kind_ff;

   logic [CFG_W-1:0]     gravity_ff, push_force_ff, time_step_ff, pole_mass_ff;
   logic [CFG_W-1:0]     total_mass_ff, half_length_ff, x_limit_ff;
   logic [ANG_LIM_W-1:0] angle_limit_ff;

   val_type pos_ff, vel_ff, angle_ff, rate_ff;
   logic        end_seen_ff;
   logic [15:0] steps_after_end_ff;
   logic [VAL_W-1:0] reward_sum_ff;
   logic push_ff, term_ff, rwd_ff;

   val_type s_ff, c_ff, pml_ff, t1_ff, t2_ff, temp_ff, den_ff, tacc_ff, xacc_ff;
   val_type vn_ff, wn_ff;

   val_type op_a_ff, op_b_ff;
   logic signed [63:0] prod_ff;

   logic                div_neg_ff, div_zero_ff;
   logic [DIV_BITS-1:0] num_ff;
   logic [VAL_W-1:0]    ub_ff, rem_ff;

   logic            red_neg_ff;
   logic [Z_W-1:0]  red_mag_ff;
   logic signed [CZ_W-1:0] cx_ff, cy_ff, cz_ff;
   logic            flip_ff;

   logic rsp_valid_ff;
   val_type out_pos_ff, out_vel_ff, out_angle_ff, out_rate_ff;
   logic out_term_ff, out_rwd_ff;
   logic [VAL_W-1:0] out_sum_ff;

   // Operand selection for the step program.
   op_type  op_kind;
   val_type op_a, op_b, force_val;
   always_comb begin
      force_val = push_ff ? $signed({1'b0, push_force_ff})
                          : -$signed({1'b0, push_force_ff});
      op_kind = OP_MUL;
      op_a    = '0;
      op_b    = '0;
      case (pc_ff)
         5'd0:  begin op_a = $signed({1'b0, pole_mass_ff}); op_b = $signed({1'b0, half_length_ff}); end
         5'd1:  begin op_a = rate_ff; op_b = rate_ff; end
         5'd2:  begin op_a = pml_ff; op_b = t1_ff; end
         5'd3:  begin op_a = t1_ff; op_b = s_ff; end
         5'd4:  begin op_kind = OP_ADD; op_a = force_val; op_b = t1_ff; end
         5'd5:  begin op_kind = OP_DIV; op_a = t1_ff; op_b = $signed({1'b0, total_mass_ff}); end
         5'd6:  begin op_a = c_ff; op_b = c_ff; end
         5'd7:  begin op_a = $signed({1'b0, pole_mass_ff}); op_b = t1_ff; end
         5'd8:  begin op_kind = OP_DIV; op_a = t1_ff; op_b = $signed({1'b0, total_mass_ff}); end
         5'd9:  begin op_kind = OP_SUB; op_a = VAL_W'(FOUR_THIRDS); op_b = t1_ff; end
         5'd10: begin op_a = $signed({1'b0, half_length_ff}); op_b = t1_ff; end
         5'd11: begin op_a = $signed({1'b0, gravity_ff}); op_b = s_ff; end
         5'd12: begin op_a = c_ff; op_b = temp_ff; end
         5'd13: begin op_kind = OP_SUB; op_a = t1_ff; op_b = t2_ff; end
         5'd14: begin op_kind = OP_DIV; op_a = t1_ff; op_b = den_ff; end
         5'd15: begin op_a = pml_ff; op_b = tacc_ff; end
         5'd16: begin op_a = t1_ff; op_b = c_ff; end
         5'd17: begin op_kind = OP_DIV; op_a = t1_ff; op_b = $signed({1'b0, total_mass_ff}); end
         5'd18: begin op_kind = OP_SUB; op_a = temp_ff; op_b = t1_ff; end
         5'd19: begin op_a = $signed({1'b0, time_step_ff}); op_b = xacc_ff; end
         5'd20: begin op_kind = OP_ADD; op_a = vel_ff; op_b = t1_ff; end
         5'd21: begin op_a = $signed({1'b0, time_step_ff}); op_b = SEMI_IMPLICIT ? vn_ff : vel_ff; end
         5'd22: begin op_kind = OP_ADD; op_a = pos_ff; op_b = t1_ff; end
         5'd23: begin op_a = $signed({1'b0, time_step_ff}); op_b = tacc_ff; end
         5'd24: begin op_kind = OP_ADD; op_a = rate_ff; op_b = t1_ff; end
         5'd25: begin op_a = $signed({1'b0, time_step_ff}); op_b = SEMI_IMPLICIT ? wn_ff : rate_ff; end
         5'd26: begin op_kind = OP_ADD; op_a = angle_ff; op_b = t1_ff; end
         default: begin op_kind = OP_MUL; op_a = '0; op_b = '0; end
      endcase
   end

   // Result of the finished operation.
   logic signed [63:0] mul_sh;
   logic signed [VAL_W:0] sum33;
   val_type div_res, wb_res;
   always_comb begin
      mul_sh = prod_ff >>> FRAC_BITS;
      if (op_kind_ff == OP_SUB) sum33 = {op_a_ff[VAL_W-1], op_a_ff} - {op_b_ff[VAL_W-1], op_b_ff};
      else                      sum33 = {op_a_ff[VAL_W-1], op_a_ff} + {op_b_ff[VAL_W-1], op_b_ff};
      if (div_zero_ff)
         div_res = op_a_ff[VAL_W-1] ? VAL_MIN : VAL_MAX;
      else if (!div_neg_ff)
         div_res = (num_ff > DIV_BITS'(VAL_MAX)) ? VAL_MAX : num_ff[VAL_W-1:0];
      else
         div_res = (num_ff > DIV_BITS'(64'd2147483648))
                   ? VAL_MIN : -$signed(num_ff[VAL_W-1:0]);
      case (op_kind_ff)
         OP_MUL:  wb_res = sat_64(mul_sh);
         OP_DIV:  wb_res = div_res;
         default: wb_res = sat_64(64'(sum33));
      endcase
   end

   // Divider step.
   logic [VAL_W:0] rem_sh;
   logic           div_ge;
   logic [VAL_W:0] rem_sub;
   logic [VAL_W-1:0] a_mag_in, b_mag_in;
   always_comb begin
      rem_sh   = {rem_ff, num_ff[DIV_BITS-1]};
      div_ge   = rem_sh >= {1'b0, ub_ff};
      rem_sub  = rem_sh - {1'b0, ub_ff};
      a_mag_in = op_a_ff[VAL_W-1] ? VAL_W'(-op_a_ff) : op_a_ff;
      b_mag_in = op_b_ff[VAL_W-1] ? VAL_W'(-op_b_ff) : op_b_ff;
   end

   // Angle reduction and fold into the CORDIC range.
   logic [Z_W+1:0] red_sub;
   logic [Z_W+1:0] red_diff;
   logic           red_ge;
   logic [VAL_W-1:0] ang_mag_in;
   logic signed [FOLD_W-1:0] z_m, z_a, z_b, z_c;
   logic fold_flip;
   always_comb begin
      red_sub    = (Z_W+2)'(Q30_TWO_PI) << cnt_ff[4:0];
      red_ge     = {2'b00, red_mag_ff} >= red_sub;
      red_diff   = {2'b00, red_mag_ff} - red_sub;
      ang_mag_in = angle_ff[VAL_W-1] ? VAL_W'(-angle_ff) : angle_ff;
      z_m = $signed({2'b00, red_mag_ff[FOLD_W-3:0]});
      z_a = red_neg_ff ? -z_m : z_m;
      z_b = z_a;
      if (z_b > FOLD_W'(Q30_PI))  z_b = z_b - FOLD_W'(Q30_TWO_PI);
      if (z_b < -FOLD_W'(Q30_PI)) z_b = z_b + FOLD_W'(Q30_TWO_PI);
      fold_flip = 1'b0;
      z_c = z_b;
      if (z_b > FOLD_W'(Q30_HALF_PI)) begin
         z_c = FOLD_W'(Q30_PI) - z_b;
         fold_flip = 1'b1;
      end else if (z_b < -FOLD_W'(Q30_HALF_PI)) begin
         z_c = -FOLD_W'(Q30_PI) - z_b;
         fold_flip = 1'b1;
      end
   end

   // CORDIC rotation step.
   logic signed [CZ_W-1:0] cdx, cdy, cat, cx_fin;
   always_comb begin
      cdx    = cy_ff >>> cnt_ff[4:0];
      cdy    = cx_ff >>> cnt_ff[4:0];
      cat    = atan_q30(cnt_ff[4:0]);
      cx_fin = flip_ff ? -cx_ff : cx_ff;
   end

   // Termination against the limits.
   logic signed [VAL_W:0] pos33, ang33, xl33, al33;
   logic term_in;
   always_comb begin
      pos33 = {pos_ff[VAL_W-1], pos_ff};
      ang33 = {angle_ff[VAL_W-1], angle_ff};
      xl33  = $signed({2'b00, x_limit_ff});
      al33  = $signed({{(VAL_W+1-ANG_LIM_W){1'b0}}, angle_limit_ff});
      term_in = (pos33 < -xl33) || (pos33 > xl33) || (ang33 < -al33) || (ang33 > al33);
   end

   logic req_acc;
   assign req_acc = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         cnt_ff             <= '0;
         pc_ff              <= '0;
         op_kind_ff         <= OP_MUL;
         gravity_ff         <= 31'd642253;
         push_force_ff      <= 31'd655360;
         time_step_ff       <= 31'd1311;
         pole_mass_ff       <= 31'd6554;
         total_mass_ff      <= 31'd72090;
         half_length_ff     <= 31'd32768;
         x_limit_ff         <= 31'd157286;
         angle_limit_ff     <= 18'd13726;
         pos_ff             <= '0;
         vel_ff             <= '0;
         angle_ff           <= '0;
         rate_ff            <= '0;
         end_seen_ff        <= 1'b0;
         steps_after_end_ff <= '0;
         reward_sum_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_GRAVITY:     gravity_ff     <= csr_wdata;
               REG_PUSH_FORCE:  push_force_ff  <= csr_wdata;
               REG_TIME_STEP:   time_step_ff   <= csr_wdata;
               REG_POLE_MASS:   pole_mass_ff   <= csr_wdata;
               REG_TOTAL_MASS:  total_mass_ff  <= csr_wdata;
               REG_HALF_LENGTH: half_length_ff <= csr_wdata;
               REG_X_LIMIT:     x_limit_ff     <= csr_wdata;
               REG_ANGLE_LIMIT: angle_limit_ff <= csr_wdata[ANG_LIM_W-1:0];
               default: ;
            endcase
         end

         // drop the beat once taken, unless a new one loads this cycle
         if (rsp_bus.ready && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_bus.cmd == CMD_LOAD) begin
                     pos_ff             <= req_bus.load_pos;
                     vel_ff             <= req_bus.load_vel;
                     angle_ff           <= req_bus.load_angle;
                     rate_ff            <= req_bus.load_ang_vel;
                     end_seen_ff        <= 1'b0;
                     steps_after_end_ff <= '0;
                     reward_sum_ff      <= '0;
                     term_ff            <= 1'b0;
                     rwd_ff             <= 1'b0;
                     state_ff           <= ST_DONE;
                  end else begin
                     push_ff    <= req_bus.push_right;
                     red_neg_ff <= angle_ff[VAL_W-1];
                     red_mag_ff <= {ang_mag_in, {ANG_SHIFT{1'b0}}};
                     cnt_ff     <= 6'(RED_TOP);
                     state_ff   <= ST_REDUCE;
                  end
               end
            end
            ST_REDUCE: begin
               if (red_ge) red_mag_ff <= red_diff[Z_W-1:0];
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               cx_ff    <= CZ_W'(CORDIC_GAIN);
               cy_ff    <= '0;
               cz_ff    <= z_c[CZ_W-1:0];
               flip_ff  <= fold_flip;
               cnt_ff   <= '0;
               state_ff <= ST_CORDIC;
            end
            ST_CORDIC: begin
               if (cz_ff >= 0) begin
                  cx_ff <= cx_ff - cdx;
                  cy_ff <= cy_ff + cdy;
                  cz_ff <= cz_ff - cat;
               end else begin
                  cx_ff <= cx_ff + cdx;
                  cy_ff <= cy_ff - cdy;
                  cz_ff <= cz_ff + cat;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'(CORDIC_STEPS - 1)) state_ff <= ST_TRIG;
            end
            ST_TRIG: begin
               s_ff     <= VAL_W'(cy_ff >>> ANG_SHIFT);
               c_ff     <= VAL_W'(cx_fin >>> ANG_SHIFT);
               pc_ff    <= '0;
               state_ff <= ST_ISSUE;
            end
            ST_ISSUE: begin
               op_a_ff    <= op_a;
               op_b_ff    <= op_b;
               op_kind_ff <= op_kind;
               case (op_kind)
                  OP_MUL:  state_ff <= ST_MUL;
                  OP_DIV:  state_ff <= ST_DIV_INIT;
                  default: state_ff <= ST_WB;
               endcase
            end
            ST_MUL: begin
               prod_ff  <= 64'(op_a_ff) * 64'(op_b_ff);
               state_ff <= ST_WB;
            end
            ST_DIV_INIT: begin
               div_neg_ff  <= op_a_ff[VAL_W-1] ^ op_b_ff[VAL_W-1];
               div_zero_ff <= (op_b_ff == '0);
               num_ff      <= {a_mag_in, {FRAC_BITS{1'b0}}};
               ub_ff       <= b_mag_in;
               rem_ff      <= '0;
               cnt_ff      <= '0;
               state_ff    <= ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
               rem_ff <= div_ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
               num_ff <= {num_ff[DIV_BITS-2:0], div_ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'(DIV_BITS - 1)) state_ff <= ST_WB;
            end
            ST_WB: begin
               case (pc_ff)
                  5'd0:    pml_ff   <= wb_res;
                  5'd5:    temp_ff  <= wb_res;
                  5'd10:   den_ff   <= wb_res;
                  5'd12:   t2_ff    <= wb_res;
                  5'd14:   tacc_ff  <= wb_res;
                  5'd18:   xacc_ff  <= wb_res;
                  5'd20:   vn_ff    <= wb_res;
                  5'd22:   pos_ff   <= wb_res;
                  5'd24:   wn_ff    <= wb_res;
                  5'd26:   angle_ff <= wb_res;
                  default: t1_ff    <= wb_res;
               endcase
               if (pc_ff == PC_LAST) begin
                  state_ff <= ST_SCORE;
               end else begin
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_SCORE: begin
               vel_ff  <= vn_ff;
               rate_ff <= wn_ff;
               term_ff <= term_in;
               if (!term_in) begin
                  rwd_ff <= 1'b1;
                  if (reward_sum_ff != '1) reward_sum_ff <= reward_sum_ff + 1'b1;
               end else if (!end_seen_ff) begin
                  end_seen_ff        <= 1'b1;
                  steps_after_end_ff <= '0;
                  rwd_ff             <= 1'b1;
                  if (reward_sum_ff != '1) reward_sum_ff <= reward_sum_ff + 1'b1;
               end else begin
                  if (steps_after_end_ff != '1)
                     steps_after_end_ff <= steps_after_end_ff + 1'b1;
                  rwd_ff <= 1'b0;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  out_pos_ff   <= pos_ff;
                  out_vel_ff   <= vel_ff;
                  out_angle_ff <= angle_ff;
                  out_rate_ff  <= rate_ff;
                  out_term_ff  <= term_ff;
                  out_rwd_ff   <= rwd_ff;
                  out_sum_ff   <= reward_sum_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.cart_position = out_pos_ff;
   assign rsp_bus.cart_velocity = out_vel_ff;
   assign rsp_bus.pole_angle    = out_angle_ff;
   assign rsp_bus.pole_rate     = out_rate_ff;
   assign rsp_bus.terminated    = out_term_ff;
   assign rsp_bus.reward        = out_rwd_ff;
   assign rsp_bus.reward_total  = out_sum_ff;

   // An accepted beat takes the block out of idle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_bus.ready)
      else $error("request side still ready after an accepted beat");

   // Reward total only drops on a load.
   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_acc && req_bus.cmd == CMD_LOAD) |=> reward_sum_ff >= $past(reward_sum_ff))
      else $error("reward total decreased without a load");

   // Divider count stays within the quotient width.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_RUN |-> cnt_ff < 6'(DIV_BITS))
      else $error("divider ran past its last quotient bit");

endmodule
`default_nettype wire
